FILE: hw/rtl/ccf_pkg.sv
`default_nettype none

package ccf_pkg;

  // Coordinate and datapath widths. The weight width covers the largest
  // step count (32 steps give a weight total of 32768).
  localparam int COORD_W = 32;
  localparam int WGT_W   = 16;
  localparam int PROD_W  = COORD_W + WGT_W + 1;
  localparam int NUM_W   = PROD_W + 2;
  localparam int NCTRL   = 4;

  // Primitive kinds.
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_CUBIC   = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [WGT_W-1:0] wgt_t;

  // One input beat: a segment or a cubic Bezier primitive.
  typedef struct packed {
    logic   kind;
    logic   first_point;
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_one_x;
    coord_t ctrl_one_y;
    coord_t ctrl_two_x;
    coord_t ctrl_two_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  // One output beat: a polyline point.
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_of_run;
  } out_item_t;

  // One point request from the sequencer to the arithmetic pipeline.
  // Entry 0 of each array belongs to the start point, entry 3 to the end.
  typedef struct packed {
    logic                  valid;
    logic                  last;
    wgt_t   [NCTRL-1:0]    wgt;
    coord_t [NCTRL-1:0]    px;
    coord_t [NCTRL-1:0]    py;
  } iss_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ccf_front.sv
`default_nettype none

module ccf_front
  import ccf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  output in_item_t      cmd_data,
  input  wire logic     cmd_pop
);

  // Two-entry queue of accepted primitives.
  in_item_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // The queue is full when both slots hold a primitive.
  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ccf_back.sv
`default_nettype none

module ccf_back
  import ccf_pkg::*;
#(
  parameter int CURVE_STEPS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     cmd_valid,
  input  wire in_item_t cmd_data,
  output logic          cmd_pop,
  output iss_t          iss
);

  localparam int KW    = $clog2(CURVE_STEPS + 1);
  localparam int TOTAL = CURVE_STEPS * CURVE_STEPS * CURVE_STEPS;

  // Bernstein weight table, one row per step index.
  logic [NCTRL-1:0][WGT_W-1:0] wtab [CURVE_STEPS+1];

  for (genvar gk = 0; gk <= CURVE_STEPS; gk++) begin : g_wtab
    localparam int U = CURVE_STEPS - gk;
    assign wtab[gk][0] = WGT_W'(U * U * U);
    assign wtab[gk][1] = WGT_W'(3 * U * U * gk);
    assign wtab[gk][2] = WGT_W'(3 * U * gk * gk);
    assign wtab[gk][3] = WGT_W'(gk * gk * gk);
  end

  in_item_t            cur_r;
  logic                busy_r, busy_nxt;
  logic                start_pend_r, start_pend_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                iss_vld_r;
  logic                iss_last_r;
  wgt_t [NCTRL-1:0]    iss_wgt_r;
  coord_t [NCTRL-1:0]  iss_px_r;
  coord_t [NCTRL-1:0]  iss_py_r;

  logic                fire;
  logic                done_c;
  logic                last_c;
  wgt_t [NCTRL-1:0]    wgt_c;

  // Pick the weights of the next point. A plain point (the start point or
  // a segment end) uses the full weight total on one control point, which
  // the rounding divide returns unchanged.
  always_comb begin
    wgt_c  = '0;
    last_c = 1'b0;
    done_c = 1'b0;
    if (start_pend_r) begin
      wgt_c[0] = WGT_W'(TOTAL);
    end else if (cur_r.kind == KIND_SEGMENT) begin
      wgt_c[3] = WGT_W'(TOTAL);
      last_c   = 1'b1;
      done_c   = 1'b1;
    end else begin
      wgt_c  = wtab[k_r];
      last_c = (k_r == KW'(CURVE_STEPS));
      done_c = last_c;
    end
  end

  // Sequencing: load the next primitive on the beat that finishes this one.
  always_comb begin
    fire    = busy_r && en;
    cmd_pop = cmd_valid && (!busy_r || (fire && done_c));

    busy_nxt       = busy_r;
    start_pend_nxt = start_pend_r;
    k_nxt          = k_r;
    if (cmd_pop) begin
      busy_nxt       = 1'b1;
      start_pend_nxt = cmd_data.first_point;
      k_nxt          = KW'(1);
    end else if (fire) begin
      if (done_c) begin
        busy_nxt = 1'b0;
      end
      if (start_pend_r) begin
        start_pend_nxt = 1'b0;
      end else if (cur_r.kind == KIND_CUBIC) begin
        k_nxt = KW'(k_r + KW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      start_pend_r <= 1'b0;
      k_r          <= '0;
      iss_vld_r    <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      start_pend_r <= start_pend_nxt;
      k_r          <= k_nxt;
      if (en) begin
        iss_vld_r <= fire;
      end
    end
  end

  // Current primitive and the issue register payload.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd_data;
    end
    if (en) begin
      iss_last_r <= last_c;
      iss_wgt_r  <= wgt_c;
      iss_px_r   <= {cur_r.end_x, cur_r.ctrl_two_x, cur_r.ctrl_one_x, cur_r.start_x};
      iss_py_r   <= {cur_r.end_y, cur_r.ctrl_two_y, cur_r.ctrl_one_y, cur_r.start_y};
    end
  end

  assign iss.valid = iss_vld_r;
  assign iss.last  = iss_last_r;
  assign iss.wgt   = iss_wgt_r;
  assign iss.px    = iss_px_r;
  assign iss.py    = iss_py_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ccf_point_pipe.sv
`default_nettype none

module ccf_point_pipe
  import ccf_pkg::*;
#(
  parameter int CURVE_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire iss_t iss,
  output logic      pt_valid,
  output out_item_t pt_data
);

  localparam int TOTAL  = CURVE_STEPS * CURVE_STEPS * CURVE_STEPS;
  localparam int DIV    = 2 * TOTAL;
  localparam int DIV_W  = $clog2(DIV);
  localparam int SHR    = COORD_W + DIV_W;
  localparam int RCP_W  = COORD_W + 1;
  localparam int LO_W   = NUM_W / 2;
  localparam int HI_W   = NUM_W - LO_W;
  localparam int PHI_W  = HI_W + RCP_W;
  localparam int PLO_W  = LO_W + RCP_W;
  localparam int FULL_W = NUM_W + RCP_W;
  localparam int NSTG   = 7;
  localparam logic [NUM_W-1:0] TOT_N = NUM_W'(TOTAL);
  localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIV);
  localparam logic [NUM_W-1:0] OFFS  = NUM_W'(DIV) << (COORD_W - 1);
  localparam logic [RCP_W-1:0] RCP   = RCP_W'((longint'(1) << SHR) / longint'(DIV));

  // Index 0 is x, index 1 is y.
  logic signed [PROD_W-1:0] prod_r  [2][NCTRL];
  logic signed [PROD_W:0]   pair_r  [2][2];
  logic signed [NUM_W-1:0]  sum_c   [2];
  logic [NUM_W-1:0]         num_r   [2];
  logic [NUM_W-1:0]         num1_r  [2];
  logic [NUM_W-1:0]         num2_r  [2];
  logic [PHI_W-1:0]         phi_r   [2];
  logic [PLO_W-1:0]         plo_r   [2];
  logic [FULL_W-1:0]        full_c  [2];
  logic [COORD_W-1:0]       qest_r  [2];
  logic [COORD_W-1:0]       qest1_r [2];
  logic [NUM_W-1:0]         rem_r   [2];
  logic [COORD_W-1:0]       quo_r   [2];
  logic                     vld_r   [NSTG];
  logic                     last_r  [NSTG];

  // Weighted control points.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCTRL; i++) begin
        prod_r[0][i] <= $signed(iss.px[i]) * $signed({1'b0, iss.wgt[i]});
        prod_r[1][i] <= $signed(iss.py[i]) * $signed({1'b0, iss.wgt[i]});
      end
    end
  end

  // Pairwise sums, then the biased numerator 2*sum + total, shifted up by
  // 2^31 divisors so that the floor divide sees a non-negative value.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sum_c[c] = NUM_W'(pair_r[c][0]) + NUM_W'(pair_r[c][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        pair_r[c][0] <= (PROD_W+1)'(prod_r[c][0]) + (PROD_W+1)'(prod_r[c][1]);
        pair_r[c][1] <= (PROD_W+1)'(prod_r[c][2]) + (PROD_W+1)'(prod_r[c][3]);
        num_r[c]     <= (sum_c[c] <<< 1) + TOT_N + OFFS;
      end
    end
  end

  // Floor divide by the constant 2*total. The numerator stays below 2^SHR,
  // so the truncated reciprocal gives an estimate that is exact or one
  // short; a single compare of the remainder settles the quotient.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      full_c[c] = (FULL_W'(phi_r[c]) << LO_W) + FULL_W'(plo_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        // Reciprocal product, taken over the two halves of the numerator.
        phi_r[c]   <= PHI_W'(num_r[c][NUM_W-1:LO_W]) * PHI_W'(RCP);
        plo_r[c]   <= PLO_W'(num_r[c][LO_W-1:0]) * PLO_W'(RCP);
        num1_r[c]  <= num_r[c];
        // Quotient estimate and the numerator it belongs to.
        qest_r[c]  <= full_c[c][SHR +: COORD_W];
        num2_r[c]  <= num1_r[c];
        // Remainder of the estimate, then the final one-step correction.
        rem_r[c]   <= num2_r[c] - NUM_W'(qest_r[c]) * DIV_N;
        qest1_r[c] <= qest_r[c];
        quo_r[c]   <= qest1_r[c] + COORD_W'(rem_r[c] >= DIV_N);
      end
    end
  end

  // Beat valid and last flag travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= iss.valid;
      for (int s = 1; s < NSTG; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= iss.last;
      for (int s = 1; s < NSTG; s++) begin
        last_r[s] <= last_r[s-1];
      end
    end
  end

  // Remove the 2^31 bias by flipping the top quotient bit.
  assign pt_valid            = vld_r[NSTG-1];
  assign pt_data.point_x     = {~quo_r[0][COORD_W-1], quo_r[0][COORD_W-2:0]};
  assign pt_data.point_y     = {~quo_r[1][COORD_W-1], quo_r[1][COORD_W-2:0]};
  assign pt_data.last_of_run = last_r[NSTG-1];

endmodule

`default_nettype wire

FILE: hw/rtl/cubic_curve_flattener.sv
// Throughput: one output point per cycle while the output is not stalled;
// a primitive gives 1 to CURVE_STEPS+1 points of the point sequencer, and
// primitives follow with no gap.
// The point pipeline (multiply, add, reciprocal divide) is held as a whole while
// the output is stalled; a two-entry queue keeps taking input meanwhile.
// Reset (rst_n low, synchronous) empties the queue and the pipeline.
`default_nettype none

module cubic_curve_flattener
  import ccf_pkg::*;
#(
  parameter int CURVE_STEPS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic     cmd_valid;
  in_item_t cmd_data;
  logic     cmd_pop;
  logic     en;
  iss_t     iss;

  // The whole point pipeline advances unless the output beat is held.
  assign en = !out_valid || !out_stall;

  ccf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  ccf_back #(
    .CURVE_STEPS (CURVE_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .iss       (iss)
  );

  ccf_point_pipe #(
    .CURVE_STEPS (CURVE_STEPS)
  ) u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .iss      (iss),
    .pt_valid (out_valid),
    .pt_data  (out_data)
  );

  // The sequencer only takes a primitive that the queue holds.
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("sequencer popped an empty queue");

  // A full queue always presents a primitive to the sequencer.
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> cmd_valid)
    else $error("input stalled while the queue head is empty");

  // A point issued while the pipeline is held must stay issued.
  a_issue_held: assert property (@(posedge clk) disable iff (!rst_n)
    (iss.valid && !en) |=> iss.valid)
    else $error("issued point lost while the pipeline was held");

endmodule

`default_nettype wire
